// ===== hw/rtl/segbox_pkg.sv =====
// Shared types and constants for the segment versus box intersection block.
// Holds the coordinate types and the side-band structures that travel along the pipeline.
// No dependencies.
`default_nettype none

package segbox_pkg;

    localparam int AXES = 3;
    localparam int DIVS = 6;
    localparam int CW   = 32;
    localparam int DW   = 33;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [DW-1:0] t_diff;

    typedef struct packed {
        logic [AXES-1:0][CW-1:0] s;
        logic [AXES-1:0][DW-1:0] d;
        logic [AXES-1:0]         dz;
        logic                    miss;
    } t_side;

    typedef struct packed {
        logic neg;
        logic zero;
        logic sat;
    } t_dflag;

endpackage : segbox_pkg

`default_nettype wire

// ===== hw/rtl/segment_box_intersection.sv =====
// Segment versus axis-aligned box intersection (slab test) in signed Q16.16.
// Uses segbox_pkg for its types; contains the whole pipeline.
//
// A request carries the box corners and the segment end points on the input
// channel (i_valid, o_stall). Each request gives exactly one result on the
// output channel (o_valid, i_stall): a hit count of 0 to 2, then the points
// on the segment, entry before exit, with unused points reading as zero.
// The block is one pipeline of PARAM_FRAC_BITS + 10 register stages, 34 for
// the default. Six restoring dividers, one quotient bit per stage, produce
// the slab parameters, and one register stage each forms the differences,
// magnitudes, saturation checks, final parameters, slab bounds, entry and
// exit, products, rounding and the output. A new request is taken every
// cycle unless stalled. When the receiver stalls a valid result, the whole
// pipeline holds and o_stall goes high in the same cycle; nothing is lost
// or repeated. Reset clears every valid bit, so the pipeline comes up empty.
`default_nettype none

module segment_box_intersection #(
    parameter int PARAM_FRAC_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  segbox_pkg::t_coord i_box_min_x,
    input  segbox_pkg::t_coord i_box_min_y,
    input  segbox_pkg::t_coord i_box_min_z,
    input  segbox_pkg::t_coord i_box_max_x,
    input  segbox_pkg::t_coord i_box_max_y,
    input  segbox_pkg::t_coord i_box_max_z,
    input  segbox_pkg::t_coord i_start_x,
    input  segbox_pkg::t_coord i_start_y,
    input  segbox_pkg::t_coord i_start_z,
    input  segbox_pkg::t_coord i_end_x,
    input  segbox_pkg::t_coord i_end_y,
    input  segbox_pkg::t_coord i_end_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_hit_count,
    output segbox_pkg::t_coord o_first_x,
    output segbox_pkg::t_coord o_first_y,
    output segbox_pkg::t_coord o_first_z,
    output segbox_pkg::t_coord o_second_x,
    output segbox_pkg::t_coord o_second_y,
    output segbox_pkg::t_coord o_second_z
);
    import segbox_pkg::*;

    localparam int P  = PARAM_FRAC_BITS;
    localparam int QW = P + 1;
    localparam int NS = P + 1;
    localparam int TW = P + 3;
    localparam int MW = DW + TW;
    localparam int RW = DW + 1;

    localparam logic signed [TW-1:0] T_TWO  = {3'b010, {P{1'b0}}};
    localparam logic signed [TW-1:0] T_ONE  = {3'b001, {P{1'b0}}};
    localparam logic signed [TW-1:0] T_NTWO = -T_TWO;
    localparam logic signed [MW-1:0] HALF   = {{(MW-P){1'b0}}, 1'b1, {(P-1){1'b0}}};

    logic adv;
    assign adv     = !o_valid || !i_stall;
    assign o_stall = !adv;

    t_coord in_lo [AXES];
    t_coord in_hi [AXES];
    t_coord in_s  [AXES];
    t_coord in_e  [AXES];

    assign in_lo[0] = i_box_min_x;
    assign in_lo[1] = i_box_min_y;
    assign in_lo[2] = i_box_min_z;
    assign in_hi[0] = i_box_max_x;
    assign in_hi[1] = i_box_max_y;
    assign in_hi[2] = i_box_max_z;
    assign in_s[0]  = i_start_x;
    assign in_s[1]  = i_start_y;
    assign in_s[2]  = i_start_z;
    assign in_e[0]  = i_end_x;
    assign in_e[1]  = i_end_y;
    assign in_e[2]  = i_end_z;

    // Stage 1: differences.
    logic   r1_v;
    t_coord r1_s [AXES];
    t_diff  r1_d [AXES];
    t_diff  r1_a [AXES];
    t_diff  r1_b [AXES];
    t_diff  n1_d [AXES];
    t_diff  n1_a [AXES];
    t_diff  n1_b [AXES];

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            n1_d[i] = $signed({in_e[i][CW-1], in_e[i]}) - $signed({in_s[i][CW-1], in_s[i]});
            n1_a[i] = $signed({in_lo[i][CW-1], in_lo[i]}) - $signed({in_s[i][CW-1], in_s[i]});
            n1_b[i] = $signed({in_hi[i][CW-1], in_hi[i]}) - $signed({in_s[i][CW-1], in_s[i]});
        end
    end

    // Stage 2: magnitudes and signs.
    logic            r2_v;
    t_side           r2_side;
    logic [DW-1:0]   r2_num [DIVS];
    logic [DW-1:0]   r2_den [AXES];
    logic [DIVS-1:0] r2_neg;
    t_side           n2_side;
    logic [DW-1:0]   n2_num [DIVS];
    logic [DW-1:0]   n2_den [AXES];
    logic [DIVS-1:0] n2_neg;

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            n2_side.s[i]  = r1_s[i];
            n2_side.d[i]  = r1_d[i];
            n2_side.dz[i] = (r1_d[i] == '0);
            n2_den[i]     = r1_d[i][DW-1] ? DW'(-r1_d[i]) : DW'(r1_d[i]);
            n2_num[i]     = r1_a[i][DW-1] ? DW'(-r1_a[i]) : DW'(r1_a[i]);
            n2_num[i+AXES] = r1_b[i][DW-1] ? DW'(-r1_b[i]) : DW'(r1_b[i]);
            n2_neg[i]      = r1_a[i][DW-1] ^ r1_d[i][DW-1];
            n2_neg[i+AXES] = r1_b[i][DW-1] ^ r1_d[i][DW-1];
        end
        n2_side.miss = 1'b0;
        for (int i = 0; i < AXES; i++) begin
            if ((r1_d[i] == '0) && ((r1_a[i] > 0) || r1_b[i][DW-1])) begin
                n2_side.miss = 1'b1;
            end
        end
    end

    // Stage 3: zero and saturation checks.
    logic          r3_v;
    t_side         r3_side;
    logic [DW-1:0] r3_num [DIVS];
    logic [DW-1:0] r3_den [AXES];
    t_dflag        r3_flag [DIVS];
    t_dflag        n3_flag [DIVS];

    always_comb begin
        for (int l = 0; l < DIVS; l++) begin
            n3_flag[l].neg  = r2_neg[l];
            n3_flag[l].zero = (r2_num[l] == '0);
            n3_flag[l].sat  = {1'b0, r2_num[l]} >= {r2_den[l % AXES], 1'b0};
        end
    end

    // Divider stages, one quotient bit each.
    logic          rd_v    [NS];
    t_side         rd_side [NS];
    logic [DW-1:0] rd_den  [NS][AXES];
    t_dflag        rd_flag [NS][DIVS];
    logic [RW-1:0] rd_rem  [NS][DIVS];
    logic [QW-1:0] rd_quo  [NS][DIVS];

    t_side         din_side [NS];
    logic [DW-1:0] din_den  [NS][AXES];
    t_dflag        din_flag [NS][DIVS];
    logic [RW-1:0] din_rem  [NS][DIVS];
    logic [QW-1:0] din_quo  [NS][DIVS];
    logic          dv_bit   [NS][DIVS];
    logic [RW-1:0] dv_rem   [NS][DIVS];

    always_comb begin
        din_side[0] = r3_side;
        for (int i = 0; i < AXES; i++) begin
            din_den[0][i] = r3_den[i];
        end
        for (int l = 0; l < DIVS; l++) begin
            din_flag[0][l] = r3_flag[l];
            din_rem[0][l]  = {1'b0, r3_num[l]};
            din_quo[0][l]  = '0;
        end
        for (int k = 1; k < NS; k++) begin
            din_side[k] = rd_side[k-1];
            for (int i = 0; i < AXES; i++) begin
                din_den[k][i] = rd_den[k-1][i];
            end
            for (int l = 0; l < DIVS; l++) begin
                din_flag[k][l] = rd_flag[k-1][l];
                din_rem[k][l]  = {rd_rem[k-1][l][RW-2:0], 1'b0};
                din_quo[k][l]  = rd_quo[k-1][l];
            end
        end
        for (int k = 0; k < NS; k++) begin
            for (int l = 0; l < DIVS; l++) begin
                dv_bit[k][l] = din_rem[k][l] >= {1'b0, din_den[k][l % AXES]};
                dv_rem[k][l] = dv_bit[k][l] ? din_rem[k][l] - {1'b0, din_den[k][l % AXES]}
                                            : din_rem[k][l];
            end
        end
    end

    // Stage 4: signed, saturated slab parameters.
    logic                 r4_v;
    t_side                r4_side;
    logic signed [TW-1:0] r4_t [DIVS];
    logic signed [TW-1:0] n4_t [DIVS];
    logic signed [TW-1:0] n4_q [DIVS];

    always_comb begin
        for (int l = 0; l < DIVS; l++) begin
            n4_q[l] = $signed({2'b00, rd_quo[NS-1][l]})
                    + $signed(TW'(rd_rem[NS-1][l] != '0));
            if (rd_flag[NS-1][l].zero) begin
                n4_t[l] = '0;
            end else if (rd_flag[NS-1][l].sat) begin
                n4_t[l] = rd_flag[NS-1][l].neg ? T_NTWO : T_TWO;
            end else if (rd_flag[NS-1][l].neg) begin
                n4_t[l] = -n4_q[l];
            end else begin
                n4_t[l] = $signed({2'b00, rd_quo[NS-1][l]});
            end
        end
    end

    // Stage 5: per-axis entry and exit bounds.
    logic                 r5_v;
    t_side                r5_side;
    logic signed [TW-1:0] r5_tmin [AXES];
    logic signed [TW-1:0] r5_tmax [AXES];
    logic signed [TW-1:0] n5_tmin [AXES];
    logic signed [TW-1:0] n5_tmax [AXES];

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            if (r4_side.dz[i]) begin
                n5_tmin[i] = T_NTWO;
                n5_tmax[i] = T_TWO;
            end else if (r4_t[i] < r4_t[i+AXES]) begin
                n5_tmin[i] = r4_t[i];
                n5_tmax[i] = r4_t[i+AXES];
            end else begin
                n5_tmin[i] = r4_t[i+AXES];
                n5_tmax[i] = r4_t[i];
            end
        end
    end

    // Stage 6: overall entry and exit.
    logic                 r6_v;
    t_side                r6_side;
    logic signed [TW-1:0] r6_tn;
    logic signed [TW-1:0] r6_tf;
    logic signed [TW-1:0] n6_tn;
    logic signed [TW-1:0] n6_tf;

    always_comb begin
        n6_tn = r5_tmin[0];
        n6_tf = r5_tmax[0];
        for (int i = 1; i < AXES; i++) begin
            if (r5_tmin[i] > n6_tn) begin
                n6_tn = r5_tmin[i];
            end
            if (r5_tmax[i] < n6_tf) begin
                n6_tf = r5_tmax[i];
            end
        end
    end

    // Stage 7: hit classification and products.
    logic                 r7_v;
    t_coord               r7_s [AXES];
    logic signed [MW-1:0] r7_pn [AXES];
    logic signed [MW-1:0] r7_pf [AXES];
    logic                 r7_nok;
    logic                 r7_fok;
    logic                 r7_nohit;
    logic signed [MW-1:0] n7_pn [AXES];
    logic signed [MW-1:0] n7_pf [AXES];

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            n7_pn[i] = $signed(r6_side.d[i]) * r6_tn;
            n7_pf[i] = $signed(r6_side.d[i]) * r6_tf;
        end
    end

    // Stage 8: rounding.
    logic                 r8_v;
    t_coord               r8_s [AXES];
    t_coord               r8_shn [AXES];
    t_coord               r8_shf [AXES];
    logic                 r8_nok;
    logic                 r8_fok;
    logic                 r8_nohit;
    logic signed [MW-1:0] n8_sn [AXES];
    logic signed [MW-1:0] n8_sf [AXES];

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            n8_sn[i] = r7_pn[i] + HALF;
            n8_sf[i] = r7_pf[i] + HALF;
        end
    end

    // Output stage.
    logic       r_o_v;
    logic [1:0] r_o_cnt;
    t_coord     r_o_first  [AXES];
    t_coord     r_o_second [AXES];
    t_coord     n_pn [AXES];
    t_coord     n_pf [AXES];
    t_coord     n_first  [AXES];
    t_coord     n_second [AXES];
    logic [1:0] n_cnt;

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            n_pn[i] = r8_s[i] + r8_shn[i];
            n_pf[i] = r8_s[i] + r8_shf[i];
            if (r8_nohit) begin
                n_first[i] = '0;
            end else if (r8_nok) begin
                n_first[i] = n_pn[i];
            end else if (r8_fok) begin
                n_first[i] = n_pf[i];
            end else begin
                n_first[i] = '0;
            end
            n_second[i] = (!r8_nohit && r8_nok && r8_fok) ? n_pf[i] : '0;
        end
        n_cnt = r8_nohit ? 2'd0 : 2'({1'b0, r8_nok} + {1'b0, r8_fok});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            for (int k = 0; k < NS; k++) begin
                rd_v[k] <= 1'b0;
            end
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r6_v  <= 1'b0;
            r7_v  <= 1'b0;
            r8_v  <= 1'b0;
            r_o_v <= 1'b0;
        end else if (adv) begin
            r1_v  <= i_valid;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            rd_v[0] <= r3_v;
            for (int k = 1; k < NS; k++) begin
                rd_v[k] <= rd_v[k-1];
            end
            r4_v  <= rd_v[NS-1];
            r5_v  <= r4_v;
            r6_v  <= r5_v;
            r7_v  <= r6_v;
            r8_v  <= r7_v;
            r_o_v <= r8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < AXES; i++) begin
                r1_s[i] <= in_s[i];
                r1_d[i] <= n1_d[i];
                r1_a[i] <= n1_a[i];
                r1_b[i] <= n1_b[i];
                r2_den[i] <= n2_den[i];
                r3_den[i] <= r2_den[i];
            end
            r2_side <= n2_side;
            r2_neg  <= n2_neg;
            r3_side <= r2_side;
            for (int l = 0; l < DIVS; l++) begin
                r2_num[l]  <= n2_num[l];
                r3_num[l]  <= r2_num[l];
                r3_flag[l] <= n3_flag[l];
            end
            for (int k = 0; k < NS; k++) begin
                rd_side[k] <= din_side[k];
                for (int i = 0; i < AXES; i++) begin
                    rd_den[k][i] <= din_den[k][i];
                end
                for (int l = 0; l < DIVS; l++) begin
                    rd_flag[k][l] <= din_flag[k][l];
                    rd_rem[k][l]  <= dv_rem[k][l];
                    rd_quo[k][l]  <= {din_quo[k][l][QW-2:0], dv_bit[k][l]};
                end
            end
            r4_side <= rd_side[NS-1];
            for (int l = 0; l < DIVS; l++) begin
                r4_t[l] <= n4_t[l];
            end
            r5_side <= r4_side;
            for (int i = 0; i < AXES; i++) begin
                r5_tmin[i] <= n5_tmin[i];
                r5_tmax[i] <= n5_tmax[i];
            end
            r6_side <= r5_side;
            r6_tn   <= n6_tn;
            r6_tf   <= n6_tf;
            r7_nok   <= (r6_tn >= 0) && (r6_tn <= T_ONE);
            r7_fok   <= (r6_tf >= 0) && (r6_tf <= T_ONE);
            r7_nohit <= r6_side.miss || (r6_tn > r6_tf) || (r6_tf < 0);
            r8_nok   <= r7_nok;
            r8_fok   <= r7_fok;
            r8_nohit <= r7_nohit;
            for (int i = 0; i < AXES; i++) begin
                r7_s[i]   <= r6_side.s[i];
                r7_pn[i]  <= n7_pn[i];
                r7_pf[i]  <= n7_pf[i];
                r8_s[i]   <= r7_s[i];
                r8_shn[i] <= n8_sn[i][P+CW-1:P];
                r8_shf[i] <= n8_sf[i][P+CW-1:P];
                r_o_first[i]  <= n_first[i];
                r_o_second[i] <= n_second[i];
            end
            r_o_cnt <= n_cnt;
        end
    end

    assign o_valid     = r_o_v;
    assign o_hit_count = r_o_cnt;
    assign o_first_x   = r_o_first[0];
    assign o_first_y   = r_o_first[1];
    assign o_first_z   = r_o_first[2];
    assign o_second_x  = r_o_second[0];
    assign o_second_y  = r_o_second[1];
    assign o_second_z  = r_o_second[2];

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hit_count != 2'd3)
        else $error("hit count out of range");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit_count == 2'd0) |->
        (o_first_x == 0 && o_first_y == 0 && o_first_z == 0))
        else $error("first point not zero on a miss");

    a_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit_count != 2'd2) |->
        (o_second_x == 0 && o_second_y == 0 && o_second_z == 0))
        else $error("second point not zero with fewer than two hits");

endmodule : segment_box_intersection

`default_nettype wire

// ===== test/segment_box_intersection_test.sv =====
// Self-checking testbench for segment_box_intersection: directed slab cases, then random
// segments and boxes under three receiver and sender idling mixes. Depends on segbox_pkg.
// Each result is checked field by field against a built-in slab-test predictor.
`default_nettype none

module segment_box_intersection_test;
    timeunit 1ns;
    timeprecision 1ps;

    import segbox_pkg::*;

    localparam int PFB = 24;
    localparam longint T_ONE = longint'(1) << PFB;
    localparam longint T_TWO = longint'(2) << PFB;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        t_coord lo[3];
        t_coord hi[3];
        t_coord s[3];
        t_coord e[3];
    } t_segment_req;

    typedef struct {
        logic [1:0] hits;
        t_coord     pt[6];
    } t_hit_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [1:0] o_hit_count;
    t_coord     in_lo[3], in_hi[3], in_s[3], in_e[3];
    t_coord     o_first_x, o_first_y, o_first_z, o_second_x, o_second_y, o_second_z;

    t_hit_result expected_hits[$];
    int          error_count = 0;
    int          sent_count = 0;
    int          checked_count = 0;
    int          hit_tally[3] = '{0, 0, 0};
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          quiet_cycles = 0;

    initial begin
        for (int i = 0; i < 3; i++) begin
            in_lo[i] = '0;
            in_hi[i] = '0;
            in_s[i] = '0;
            in_e[i] = '0;
        end
    end

    segment_box_intersection dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_box_min_x(in_lo[0]), .i_box_min_y(in_lo[1]), .i_box_min_z(in_lo[2]),
        .i_box_max_x(in_hi[0]), .i_box_max_y(in_hi[1]), .i_box_max_z(in_hi[2]),
        .i_start_x(in_s[0]), .i_start_y(in_s[1]), .i_start_z(in_s[2]),
        .i_end_x(in_e[0]), .i_end_y(in_e[1]), .i_end_z(in_e[2]),
        .o_valid(o_valid), .i_stall(i_stall), .o_hit_count(o_hit_count),
        .o_first_x(o_first_x), .o_first_y(o_first_y), .o_first_z(o_first_z),
        .o_second_x(o_second_x), .o_second_y(o_second_y), .o_second_z(o_second_z)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint slab_param(longint num, longint den);
        longint un, ud, q, r;
        logic   neg;
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        neg = (num < 0) != (den < 0);
        if (un == 0) return 0;
        if (un >= 2 * ud) return neg ? -T_TWO : T_TWO;
        q = (un << PFB) / ud;
        r = (un << PFB) % ud;
        if (!neg) return q;
        return -(q + ((r != 0) ? 1 : 0));
    endfunction

    function automatic t_hit_result slab_intersect(t_segment_req q);
        t_hit_result res;
        longint      sv[3], dv[3];
        longint      a, b, t1, t2, t_in, t_out;
        int          n;
        res.hits = 2'd0;
        for (int k = 0; k < 6; k++) res.pt[k] = '0;
        t_in = -T_TWO;
        t_out = T_TWO;
        for (int i = 0; i < 3; i++) begin
            sv[i] = longint'(q.s[i]);
            dv[i] = longint'(q.e[i]) - sv[i];
            a = longint'(q.lo[i]) - sv[i];
            b = longint'(q.hi[i]) - sv[i];
            if (dv[i] == 0) begin
                if (a > 0 || b < 0) return res;
                continue;
            end
            t1 = slab_param(a, dv[i]);
            t2 = slab_param(b, dv[i]);
            if (t1 > t2) begin
                a = t1;
                t1 = t2;
                t2 = a;
            end
            if (t1 > t_in) t_in = t1;
            if (t2 < t_out) t_out = t2;
        end
        if (t_in > t_out || t_out < 0) return res;
        n = 0;
        if (t_in >= 0 && t_in <= T_ONE) begin
            for (int i = 0; i < 3; i++)
                res.pt[i] = t_coord'(sv[i] + ((dv[i] * t_in + (T_ONE >>> 1)) >>> PFB));
            n = 1;
        end
        if (t_out >= 0 && t_out <= T_ONE) begin
            for (int i = 0; i < 3; i++)
                res.pt[3 * n + i] = t_coord'(sv[i] + ((dv[i] * t_out + (T_ONE >>> 1)) >>> PFB));
            n++;
        end
        res.hits = 2'(n);
        return res;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        error_count++;
        $display("MISMATCH result %0d %s: got %0d, expected %0d", checked_count, field, got, want);
    endtask

    task automatic send_segment(t_segment_req q);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        in_lo <= q.lo;
        in_hi <= q.hi;
        in_s <= q.s;
        in_e <= q.e;
        do @(posedge i_clk); while (o_stall);
        expected_hits = {expected_hits, slab_intersect(q)};
        sent_count++;
    endtask

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_hit_result want;
        t_coord      got[6];
        if (o_valid && !i_stall) begin
            if (expected_hits.size() == 0) begin
                report_mismatch("unexpected result", o_hit_count, 0);
            end else begin
                want = expected_hits.pop_front();
                got = '{o_first_x, o_first_y, o_first_z, o_second_x, o_second_y, o_second_z};
                if (o_hit_count !== want.hits)
                    report_mismatch("hit_count", o_hit_count, want.hits);
                for (int k = 0; k < 6; k++)
                    if (got[k] !== want.pt[k])
                        report_mismatch($sformatf("point field %0d", k), got[k], want.pt[k]);
                if (want.hits <= 2) hit_tally[want.hits]++;
            end
            checked_count++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no traffic for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_segment_req make_req(t_coord lx, t_coord ly, t_coord lz,
                                              t_coord hx, t_coord hy, t_coord hz,
                                              t_coord sx, t_coord sy, t_coord sz,
                                              t_coord ex, t_coord ey, t_coord ez);
        t_segment_req q;
        q.lo = '{lx, ly, lz};
        q.hi = '{hx, hy, hz};
        q.s = '{sx, sy, sz};
        q.e = '{ex, ey, ez};
        return q;
    endfunction

    function automatic t_coord near_value(t_coord base, int span_bits);
        longint off;
        off = longint'($urandom) & ((longint'(1) << span_bits) - 1);
        return t_coord'(longint'(base) + off - (longint'(1) << (span_bits - 1)));
    endfunction

    task automatic test_corner_values();
        t_coord mn, mx, one;
        mn = 32'sh8000_0000;
        mx = 32'sh7fff_ffff;
        one = 32'sh0001_0000;
        send_segment(make_req(mn, mn, mn, mx, mx, mx, mn, mn, mn, mx, mx, mx));
        send_segment(make_req(mn, mn, mn, mx, mx, mx, mx, mx, mx, mn, mn, mn));
        send_segment(make_req(-one, -one, -one, one, one, one, mn, mn, mn, mx, mx, mx));
        send_segment(make_req(mx, mx, mx, mn, mn, mn, mx, 0, 0, mn, 0, 0));
        send_segment(make_req(mx, mx, mx, mx, mx, mx, mn, mn, mn, mx, mx, mx));
        send_segment(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_segment(make_req(-1, -1, -1, 1, 1, 1, mx, mx, mx, mn, mn, mn));
    endtask

    task automatic test_special_cases();
        t_coord u;
        u = 32'sh0001_0000;
        // Segment passing through the box, both points valid, and the reverse.
        send_segment(make_req(-u, -u, -u, u, u, u, -3*u, 0, 0, 3*u, 0, 0));
        send_segment(make_req(-u, -u, -u, u, u, u, 3*u, u/2, 0, -3*u, -u/2, 0));
        // Start inside: only the exit point. End inside: only the entry point.
        send_segment(make_req(-u, -u, -u, u, u, u, 0, 0, 0, 4*u, u, 0));
        send_segment(make_req(-u, -u, -u, u, u, u, -4*u, 0, -u, 0, 0, 0));
        // Both ends inside: no crossing.
        send_segment(make_req(-u, -u, -u, u, u, u, -u/2, 0, 0, u/2, 0, 0));
        // Zero delta on an axis with the start outside the slab, above and below.
        send_segment(make_req(-u, -u, -u, u, u, u, -3*u, 2*u, 0, 3*u, 2*u, 0));
        send_segment(make_req(-u, -u, -u, u, u, u, -3*u, 0, -2*u, 3*u, 0, -2*u));
        // Zero delta inside the slab on two axes.
        send_segment(make_req(-u, -u, -u, u, u, u, -3*u, u, -u, 3*u, u, -u));
        // Missed box and a box behind the segment start.
        send_segment(make_req(-u, -u, -u, u, u, u, -3*u, 3*u, 0, 3*u, 2*u, 0));
        send_segment(make_req(-u, -u, -u, u, u, u, 3*u, 0, 0, 5*u, 0, 0));
        // Swapped corners on every axis.
        send_segment(make_req(u, u, u, -u, -u, -u, -3*u, -u/4, u/3, 3*u, u/4, -u/3));
        // Touching a face and a point segment inside the box.
        send_segment(make_req(-u, -u, -u, u, u, u, -3*u, u, 0, 3*u, u, 0));
        send_segment(make_req(-u, -u, -u, u, u, u, 7, 9, -5, 7, 9, -5));
        // Odd fractions exercise rounding of the intersection points.
        send_segment(make_req(-u, -u, -u, u, u, u, -3*u + 7, 11, -13, 3*u - 5, 3*u + 1, 17));
    endtask

    task automatic test_random_mix(int count);
        t_segment_req q;
        t_coord       ctr;
        int           bits, pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                for (int i = 0; i < 3; i++) begin
                    q.lo[i] = $urandom;
                    q.hi[i] = $urandom;
                    q.s[i] = $urandom;
                    q.e[i] = $urandom;
                end
            end else begin
                bits = $urandom_range(4, 30);
                for (int i = 0; i < 3; i++) begin
                    ctr = (pick < 40) ? t_coord'($urandom) : near_value(0, 24);
                    q.lo[i] = near_value(ctr, bits);
                    q.hi[i] = near_value(ctr, bits);
                    if (q.lo[i] > q.hi[i] && $urandom_range(3) != 0) begin
                        q.s[i] = q.lo[i];
                        q.lo[i] = q.hi[i];
                        q.hi[i] = q.s[i];
                    end
                    q.s[i] = near_value(ctr, bits + 1);
                    q.e[i] = ($urandom_range(9) == 0) ? q.s[i] : near_value(ctr, bits + 1);
                end
            end
            send_segment(q);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_corner_values();
        test_special_cases();
        send_idle_pct = 21;
        recv_idle_pct = 47;
        test_random_mix(510);
        send_idle_pct = 47;
        recv_idle_pct = 21;
        test_random_mix(510);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(510);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d segment requests, checked %0d results.", sent_count, checked_count);
        $display("Results with zero, one and two points: %0d, %0d, %0d.",
                 hit_tally[0], hit_tally[1], hit_tally[2]);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule : segment_box_intersection_test

`default_nettype wire
